### hw/rtl/sliding_window_variance_assert.svh
// Assertion macros for the sliding window variance block.
`ifndef SLIDING_WINDOW_VARIANCE_ASSERT_SVH
`define SLIDING_WINDOW_VARIANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define SWV_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SWV_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWV_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define SWV_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/swv_pkg.sv
// Shared types and constants of the sliding window variance block.
package swv_pkg;

  localparam int SAMPLE_W = 16;
  localparam int VAR_W    = 31;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [VAR_W-1:0]    variance_t;

endpackage

### hw/rtl/swv_stream_if.sv
// Valid/ready item channels: sample input and variance output.
interface swv_in_if;
  logic              valid;
  logic              ready;
  swv_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swv_out_if;
  logic               valid;
  logic               ready;
  swv_pkg::variance_t window_variance;

  modport source (output valid, output window_variance, input ready);
  modport sink   (input valid, input window_variance, output ready);
endinterface

### hw/rtl/swv_window.sv
// Delay line memory and running sum / sum-of-squares accumulators.
module swv_window #(
  parameter int WINDOW = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  swv_pkg::sample_t                     sample_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [16+$clog2(WINDOW)-1:0]  sum_o,
  output logic        [31+$clog2(WINDOW)-1:0]  sumsq_o
);
  import swv_pkg::*;

  localparam int LOG    = $clog2(WINDOW);
  localparam int PTR_W  = LOG;
  localparam int FILL_W = LOG + 1;
  localparam int SUM_W  = SAMPLE_W + LOG;
  localparam int SQ_W   = 31 + LOG;

  sample_t            hist_mem [WINDOW];
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [FILL_W-1:0]  fill_q;
  logic               accept;
  logic               en_a, en_b;

  logic               a_valid_q, a_full_q;
  sample_t            a_sample_q, a_old_q;
  logic               b_valid_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]    sumsq_q, sumsq_d;

  sample_t            old_v;
  logic signed [31:0] new_sq, old_sq;

  assign en_b    = !b_valid_q || ready_i;
  assign en_a    = !a_valid_q || en_b;
  assign ready_o = en_a;
  assign accept  = valid_i && en_a;

  assign ptr_d = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;

  // entries not yet written read as zero
  assign old_v   = a_full_q ? a_old_q : '0;
  assign new_sq  = a_sample_q * a_sample_q;
  assign old_sq  = old_v * old_v;
  assign sum_d   = sum_q + SUM_W'(a_sample_q) - SUM_W'(old_v);
  assign sumsq_d = sumsq_q + SQ_W'(new_sq[30:0]) - SQ_W'(old_sq[30:0]);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_old_q          <= hist_mem[ptr_q];
      hist_mem[ptr_q]  <= sample_i;
      a_sample_q       <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      fill_q    <= '0;
      a_valid_q <= 1'b0;
      a_full_q  <= 1'b0;
      b_valid_q <= 1'b0;
      sum_q     <= '0;
      sumsq_q   <= '0;
    end else begin
      if (accept) begin
        ptr_q    <= ptr_d;
        a_full_q <= (fill_q == FILL_W'(WINDOW));
        if (fill_q != FILL_W'(WINDOW)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (en_a) begin
        a_valid_q <= valid_i;
      end
      if (en_b) begin
        b_valid_q <= a_valid_q;
        if (a_valid_q) begin
          sum_q   <= sum_d;
          sumsq_q <= sumsq_d;
        end
      end
    end
  end

  assign valid_o = b_valid_q;
  assign sum_o   = sum_q;
  assign sumsq_o = sumsq_q;

endmodule

### hw/rtl/swv_moments.sv
// Numerator N*sumsq - sum^2 over two register stages.
module swv_moments #(
  parameter int WINDOW = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [16+$clog2(WINDOW)-1:0]  sum_i,
  input  logic        [31+$clog2(WINDOW)-1:0]  sumsq_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [31+2*$clog2(WINDOW)-1:0]       numer_o
);
  import swv_pkg::*;

  localparam int LOG   = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_W + LOG;
  localparam int NUM_W = 31 + 2 * LOG;

  logic                 en_c, en_d;
  logic                 c_valid_q, d_valid_q;
  logic [SUM_W-1:0]     mag;
  logic [2*SUM_W-1:0]   mag_sq;
  logic [NUM_W-1:0]     n_sumsq_d, n_sumsq_q, sum_sq_q, numer_q;

  assign en_d    = !d_valid_q || ready_i;
  assign en_c    = !c_valid_q || en_d;
  assign ready_o = en_c;

  assign mag       = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign mag_sq    = mag * mag;
  assign n_sumsq_d = NUM_W'(sumsq_i) * NUM_W'(WINDOW);

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      n_sumsq_q <= n_sumsq_d;
      sum_sq_q  <= NUM_W'(mag_sq);
    end
    if (en_d) begin
      numer_q <= (n_sumsq_q >= sum_sq_q) ? n_sumsq_q - sum_sq_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (en_c) begin
        c_valid_q <= valid_i;
      end
      if (en_d) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  assign valid_o = d_valid_q;
  assign numer_o = numer_q;

endmodule

### hw/rtl/swv_div.sv
// Division by the constant N*(N-1) as a reciprocal multiply over three register stages.
module swv_div #(
  parameter int WINDOW = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [31+2*$clog2(WINDOW)-1:0]  numer_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output swv_pkg::variance_t              quotient_o
);
  import swv_pkg::*;

  localparam int LOG     = $clog2(WINDOW);
  localparam int NUM_W   = 31 + 2 * LOG;
  localparam int Divisor = WINDOW * (WINDOW - 1);
  localparam int DIV_LOG = $clog2(Divisor);
  localparam int SHIFT   = NUM_W + DIV_LOG;
  localparam int POW_W   = SHIFT + 1;
  localparam int RCP_W   = NUM_W + 1;
  localparam int HALF    = (RCP_W + 1) / 2;
  localparam int NH_W    = NUM_W - HALF;
  localparam int MH_W    = RCP_W - HALF;
  localparam int LL_W    = 2 * HALF;
  localparam int HH_W    = NH_W + MH_W;
  localparam int HL_W    = NH_W + HALF;
  localparam int LH_W    = HALF + MH_W;
  localparam int CROSS_W = RCP_W + 1;
  localparam int PROD_W  = NUM_W + RCP_W;
  localparam int QF_W    = PROD_W - SHIFT;

  // ceil(2^SHIFT / Divisor) gives the exact floor quotient for any NUM_W-bit numerator
  localparam logic [POW_W-1:0] Pow2    = POW_W'(1) << SHIFT;
  localparam logic [RCP_W-1:0] Recip   =
    RCP_W'((Pow2 + POW_W'(Divisor - 1)) / POW_W'(Divisor));
  localparam logic [HALF-1:0]  RecipLo = Recip[HALF-1:0];
  localparam logic [MH_W-1:0]  RecipHi = Recip[RCP_W-1:HALF];

  logic                 en_e, en_f, en_g;
  logic                 e_valid_q, f_valid_q, g_valid_q;
  logic [HALF-1:0]      num_lo;
  logic [NH_W-1:0]      num_hi;
  logic [LL_W-1:0]      pp_ll_q;
  logic [HH_W-1:0]      pp_hh_q;
  logic [HL_W-1:0]      pp_hl_q;
  logic [LH_W-1:0]      pp_lh_q;
  logic [PROD_W-1:0]    base_q;
  logic [CROSS_W-1:0]   cross_q;
  logic [PROD_W-1:0]    prod;
  logic [QF_W-1:0]      quo_full;
  variance_t            quo_d, quo_q;

  assign en_g    = !g_valid_q || ready_i;
  assign en_f    = !f_valid_q || en_g;
  assign en_e    = !e_valid_q || en_f;
  assign ready_o = en_e;

  assign num_lo = numer_i[HALF-1:0];
  assign num_hi = numer_i[NUM_W-1:HALF];

  assign prod     = base_q + (PROD_W'(cross_q) << HALF);
  assign quo_full = prod[PROD_W-1:SHIFT];
  assign quo_d    = (|quo_full[QF_W-1:VAR_W]) ? '1 : quo_full[VAR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      pp_ll_q <= LL_W'(num_lo) * LL_W'(RecipLo);
      pp_hh_q <= HH_W'(num_hi) * HH_W'(RecipHi);
      pp_hl_q <= HL_W'(num_hi) * HL_W'(RecipLo);
      pp_lh_q <= LH_W'(num_lo) * LH_W'(RecipHi);
    end
    if (en_f) begin
      base_q  <= {pp_hh_q, pp_ll_q};
      cross_q <= CROSS_W'(pp_hl_q) + CROSS_W'(pp_lh_q);
    end
    if (en_g) begin
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
    end else begin
      if (en_e) begin
        e_valid_q <= valid_i;
      end
      if (en_f) begin
        f_valid_q <= e_valid_q;
      end
      if (en_g) begin
        g_valid_q <= f_valid_q;
      end
    end
  end

  assign valid_o    = g_valid_q;
  assign quotient_o = quo_q;

endmodule

### hw/rtl/sliding_window_variance.sv
// Top level of the sliding window variance block.
// Takes one signed 16-bit sample per item and returns, per item, the unbiased
// variance (N*sumsq - sum^2) / (N*(N-1)) of the last WINDOW samples, truncated;
// samples before the first WINDOW items count as zeros. Throughput is one item
// per clock while the output is not stalled. The path is seven register stages:
// two for the delay line read and accumulator update, two for the numerator, and
// three for the division by the constant N*(N-1), done as a multiply by its
// reciprocal split into partial products. Each stage holds its item only while
// the stage after it is full and stalled, so bubbles collapse and input is still
// taken while a result waits at the output. The delay line is a WINDOW-deep
// memory; a fill count masks entries not yet written, so no clearing pass is
// needed after reset.
`include "sliding_window_variance_assert.svh"

module sliding_window_variance #(
  parameter int WINDOW = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swv_in_if.sink    in_i,
  swv_out_if.source out_o
);
  import swv_pkg::*;

  localparam int LOG     = $clog2(WINDOW);
  localparam int SUM_W   = SAMPLE_W + LOG;
  localparam int SQ_W    = 31 + LOG;
  localparam int NUM_W   = 31 + 2 * LOG;
  localparam int Divisor = WINDOW * (WINDOW - 1);
  localparam logic [NUM_W:0] NumLimit = (NUM_W + 1)'(Divisor) << VAR_W;

  logic                    acc_valid, acc_ready;
  logic signed [SUM_W-1:0] acc_sum;
  logic [SQ_W-1:0]         acc_sumsq;
  logic                    mom_valid, mom_ready;
  logic [NUM_W-1:0]        mom_numer;

  swv_window #(.WINDOW(WINDOW)) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .sample_i (in_i.sample),
    .valid_o  (acc_valid),
    .ready_i  (acc_ready),
    .sum_o    (acc_sum),
    .sumsq_o  (acc_sumsq)
  );

  swv_moments #(.WINDOW(WINDOW)) u_moments (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc_valid),
    .ready_o (acc_ready),
    .sum_i   (acc_sum),
    .sumsq_i (acc_sumsq),
    .valid_o (mom_valid),
    .ready_i (mom_ready),
    .numer_o (mom_numer)
  );

  swv_div #(.WINDOW(WINDOW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (mom_valid),
    .ready_o    (mom_ready),
    .numer_i    (mom_numer),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .quotient_o (out_o.window_variance)
  );

  // an all-zero square sum means every sample in the window is zero
  `SWV_ASSERT_IMPL(a_zero_sumsq, clk_i, rst_ni, acc_valid && (acc_sumsq == '0), acc_sum == '0, "sum nonzero with zero square sum")
  // quotient must fit the result width
  `SWV_ASSERT_IMPL(a_numer_range, clk_i, rst_ni, mom_valid, {1'b0, mom_numer} < NumLimit, "numerator out of range")
  // accumulators hold while their stage is stalled
  `SWV_ASSERT_NEXT(a_acc_hold, clk_i, rst_ni, acc_valid && !acc_ready, $stable(acc_sum) && $stable(acc_sumsq), "accumulators moved during stall")

endmodule

### sim/sliding_window_variance_tb.sv
// Self-checking testbench for the sliding window variance block.
`timescale 1ns / 1ps

module sliding_window_variance_tb;
  import swv_pkg::*;

  localparam int WINDOW      = 32;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int LATENCY     = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam longint VAR_MAX = 64'd2147483647;

  typedef enum int {
    BURST_RANDOM,
    BURST_CONSTANT,
    BURST_ALTERNATE,
    BURST_SMALL
  } burst_kind_e;

  logic clk_i;
  logic rst_ni;

  swv_in_if  in_if ();
  swv_out_if out_if ();

  sliding_window_variance #(
    .WINDOW(WINDOW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  sample_t   pending_samples[$];
  variance_t expected_variances[$];

  // window model
  sample_t              win_hist[WINDOW];
  logic [SLOT_W-1:0]    oldest_slot;
  logic signed [20:0]   run_sum;
  logic [35:0]          run_sq_sum;

  int   send_idle_pct;
  int   recv_stall_pct;
  logic in_taken;
  logic hold_armed;
  logic hold_taken;
  int   hold_left;
  int   fail_count;
  int   samples_in;
  int   variances_checked;
  int   cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void add_pending(input sample_t s);
    pending_samples = {pending_samples, s};
  endfunction

  function automatic void add_expected(input variance_t v);
    expected_variances = {expected_variances, v};
  endfunction

  function automatic variance_t window_variance_next(input sample_t s);
    sample_t old_s;
    longint  sq_new;
    longint  sq_old;
    longint  n_sq;
    longint  sum_sq;
    longint  numer;
    longint  quot;
    old_s = win_hist[oldest_slot];
    win_hist[oldest_slot] = s;
    sq_new = longint'(s) * longint'(s);
    sq_old = longint'(old_s) * longint'(old_s);
    run_sum = run_sum + s - old_s;
    run_sq_sum = 36'(longint'(run_sq_sum) + sq_new - sq_old);
    oldest_slot = (oldest_slot == SLOT_W'(WINDOW - 1)) ? '0 : oldest_slot + 1'b1;
    n_sq = longint'(WINDOW) * longint'(run_sq_sum);
    sum_sq = longint'(run_sum) * longint'(run_sum);
    numer = (n_sq >= sum_sq) ? n_sq - sum_sq : 64'sd0;
    quot = numer / (longint'(WINDOW) * longint'(WINDOW - 1));
    if (quot > VAR_MAX) quot = VAR_MAX;
    return variance_t'(quot);
  endfunction

  task automatic queue_burst(output int count);
    burst_kind_e kind;
    int          pick;
    sample_t     base;
    pick = $urandom_range(99);
    if (pick < 55) kind = BURST_RANDOM;
    else if (pick < 70) kind = BURST_CONSTANT;
    else if (pick < 85) kind = BURST_ALTERNATE;
    else kind = BURST_SMALL;
    count = (kind == BURST_CONSTANT || kind == BURST_ALTERNATE) ?
            $urandom_range(WINDOW + 8, WINDOW) : $urandom_range(40, 1);
    base = sample_t'($urandom);
    for (int i = 0; i < count; i++) begin
      case (kind)
        BURST_RANDOM: begin
          add_pending(sample_t'($urandom));
        end
        BURST_CONSTANT: begin
          add_pending(base);
        end
        BURST_ALTERNATE: begin
          add_pending(i[0] ? 16'sh8000 : 16'sh7fff);
        end
        default: begin
          add_pending(sample_t'(int'($urandom_range(64)) - 32));
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || (in_if.valid && !in_taken) ||
           expected_variances.size() != 0)
      @(negedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.sample <= pending_samples.pop_front();
          in_if.valid  <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output backpressure, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_armed && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    variance_t got;
    variance_t want;
    in_taken = in_if.valid && in_if.ready && rst_ni;
    if (in_taken) begin
      add_expected(window_variance_next(in_if.sample));
      samples_in++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.window_variance;
      if (expected_variances.size() == 0) begin
        $error("window_variance: no item expected, got %0d", got);
        fail_count++;
      end else begin
        want = expected_variances.pop_front();
        variances_checked++;
        if (got !== want) begin
          $error("window_variance: expected %0d, got %0d", want, got);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sliding_window_variance_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int phase_send[4];
    int phase_stall[4];
    int queued;
    int burst;
    sample_t directed[$];

    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.sample   = '0;
    out_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_taken       = 1'b0;
    hold_armed     = 1'b0;
    hold_taken     = 1'b0;
    hold_left      = 0;
    fail_count     = 0;
    samples_in     = 0;
    variances_checked = 0;
    cycle_count    = 0;
    foreach (win_hist[i]) win_hist[i] = '0;
    oldest_slot = '0;
    run_sum     = '0;
    run_sq_sum  = '0;

    phase_send  = '{0, 85, 0, 22};
    phase_stall = '{0, 0, 85, 22};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, sign boundaries, then half a window of full-swing alternation
    directed = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                 16'sh5555, 16'shaaaa};
    foreach (directed[i]) add_pending(directed[i]);
    for (int i = 0; i < 16; i++) add_pending(i[0] ? 16'sh8000 : 16'sh7fff);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_stall[p];
      queued = 0;
      while (queued < 170) begin
        queue_burst(burst);
        queued += burst;
      end
      wait_drained();
    end

    // output held off while input keeps coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queued = 0;
    while (queued < 100) begin
      queue_burst(burst);
      queued += burst;
    end
    hold_armed = 1'b1;
    wait_drained();

    repeat (LATENCY + 5) @(posedge clk_i);

    $display("%0d samples sent, %0d variances checked over %0d cycles", samples_in,
             variances_checked, cycle_count);
    $display("phases: directed, free flow, sparse input, heavy stall, mixed, long hold-off");
    if (fail_count == 0) begin
      $display("sliding_window_variance_tb OK");
    end else begin
      $display("sliding_window_variance_tb NOT OK");
    end
    $finish;
  end

endmodule
